// ===== sv/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, constants and helpers for the grid raycasting column block.
// ----------------------------------------------------------------------------
package grc_pkg;

  // Default values for the top-level parameters.
  localparam int MAP_WIDTH_DEF    = 16;
  localparam int MAP_HEIGHT_DEF   = 16;
  localparam int SCREEN_WIDTH_DEF = 160;
  localparam int VIEW_HEIGHT_DEF  = 108;
  localparam int MAX_STEPS_DEF    = 40;

  // Arithmetic unit operand widths.
  localparam int AR_W  = 64;
  localparam int AR_BW = 33;

  // Datapath widths for the camera offset and ray components.
  localparam int CAM_W = 20;
  localparam int RAY_W = 23;

  localparam logic [AR_BW-1:0] MIN_DIST = 33'd5243;
  localparam logic [AR_BW-1:0] DIST_CAP = 33'h1_0000_0000;
  localparam logic [40:0]      INF_DIST = 41'h100_0000_0000;

  localparam logic [2:0] TILE_EMPTY = 3'd0;
  localparam logic [2:0] TILE_WALL  = 3'd1;
  localparam logic [2:0] TILE_EXIT  = 3'd5;

  localparam logic OP_TILE = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic [15:0] PLAYER_X_RST = 16'd10240;
  localparam logic [15:0] PLAYER_Y_RST = 16'd7373;
  localparam logic [15:0] DIR_X_RST    = 16'd0;
  localparam logic [15:0] DIR_Y_RST    = 16'd16384;
  localparam logic [15:0] PLANE_X_RST  = 16'hD5C3;  // -10813
  localparam logic [15:0] PLANE_Y_RST  = 16'd0;

  typedef enum logic [2:0] {
    CFG_PLAYER_X = 3'd0,
    CFG_PLAYER_Y = 3'd1,
    CFG_DIR_X    = 3'd2,
    CFG_DIR_Y    = 3'd3,
    CFG_PLANE_X  = 3'd4,
    CFG_PLANE_Y  = 3'd5
  } cfg_index_t;

  typedef enum logic {
    AR_MUL = 1'b0,
    AR_DIV = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic             start;
    arith_op_t        op;
    logic [AR_W-1:0]  a;
    logic [AR_BW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic            done;
    logic [AR_W-1:0] result;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM,
    ST_RAYX,
    ST_RAYY,
    ST_DELX,
    ST_DELY,
    ST_SIDEX,
    ST_SIDEY,
    ST_STEP,
    ST_CHECK,
    ST_DIST,
    ST_HGT,
    ST_WHIT,
    ST_EMIT
  } state_t;

  // RGB565 base colors per tile code.
  function automatic logic [15:0] tile_color(input logic [2:0] code);
    logic [15:0] c;
    case (code)
      3'd2:    c = 16'h2394;  // 38,115,160
      3'd3:    c = 16'h2C88;  // 46,145,67
      3'd4:    c = 16'h8264;  // 135,76,38
      3'd5:    c = 16'h16EB;  // 20,220,90
      default: c = 16'h9144;  // 150,42,35
    endcase
    return c;
  endfunction

  // Halve each color channel of an RGB565 word.
  function automatic logic [15:0] halve(input logic [15:0] c);
    return {1'b0, c[15:12], 1'b0, c[10:6], 1'b0, c[4:1]};
  endfunction

endpackage

// ===== sv/grid_raycast_column.sv =====
// ----------------------------------------------------------------------------
// grid_raycast_column
// Casts one screen column's ray through the stored tile map by DDA stepping.
// ----------------------------------------------------------------------------
// A cast beat (tuser high) runs all its multiplications and divisions one bit
// per cycle on the shared unit in grc_arith: four divisions (camera offset,
// two ray deltas, wall height) and five shift-add multiplications whose length
// follows the multiplier's magnitude. A column then takes at most MAX_STEPS DDA
// steps, each through ST_STEP and ST_CHECK; the map lookup of each step goes
// through the registered map memory. A tile write beat returns nothing. After
// reset the block clears all MAP_WIDTH*MAP_HEIGHT map cells before in_tready
// rises. The next beat is taken while a finished result still waits on the
// output.
module grid_raycast_column #(
  parameter int MAP_WIDTH    = grc_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT   = grc_pkg::MAP_HEIGHT_DEF,
  parameter int SCREEN_WIDTH = grc_pkg::SCREEN_WIDTH_DEF,
  parameter int VIEW_HEIGHT  = grc_pkg::VIEW_HEIGHT_DEF,
  parameter int MAX_STEPS    = grc_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // column[7:0], tile_row[11:8], tile_col[15:12], tile_code[18:16]
  input  logic [23:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_column[7:0], wall_distance[23:8], wall_top[30:24], wall_bottom[37:31],
  // hit_tile[40:38], hit_side[41], wall_color[57:42]
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = $clog2(MAX_STEPS + 16 + MAP_WIDTH + MAP_HEIGHT) + 1;
  localparam int SCW   = $clog2(MAX_STEPS + 1);
  localparam int HW    = $clog2(VIEW_HEIGHT * 13) + 2;
  localparam int RW    = grc_pkg::RAY_W;

  // Configuration registers.
  logic [15:0]        player_x_r, player_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= grc_pkg::PLAYER_X_RST;
      player_y_r <= grc_pkg::PLAYER_Y_RST;
      dir_x_r    <= grc_pkg::DIR_X_RST;
      dir_y_r    <= grc_pkg::DIR_Y_RST;
      plane_x_r  <= grc_pkg::PLANE_X_RST;
      plane_y_r  <= grc_pkg::PLANE_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        grc_pkg::CFG_PLAYER_X: player_x_r <= cfg_data;
        grc_pkg::CFG_PLAYER_Y: player_y_r <= cfg_data;
        grc_pkg::CFG_DIR_X:    dir_x_r    <= cfg_data;
        grc_pkg::CFG_DIR_Y:    dir_y_r    <= cfg_data;
        grc_pkg::CFG_PLANE_X:  plane_x_r  <= cfg_data;
        grc_pkg::CFG_PLANE_Y:  plane_y_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [7:0] in_column;
  logic [3:0] in_tile_row, in_tile_col;
  logic [2:0] in_tile_code;
  assign in_column    = in_tdata[7:0];
  assign in_tile_row  = in_tdata[11:8];
  assign in_tile_col  = in_tdata[15:12];
  assign in_tile_code = in_tdata[18:16];

  // Sequencer state.
  grc_pkg::state_t state_r, state_nxt;
  logic            issued_r, issued_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Working registers.
  logic [7:0]                  column_r, column_nxt;
  logic [10:0]                 num_mag_r, num_mag_nxt;
  logic                        cam_neg_r, cam_neg_nxt;
  logic [grc_pkg::CAM_W-1:0]   cam_mag_r, cam_mag_nxt;
  logic signed [RW-1:0]        rx_r, rx_nxt, ry_r, ry_nxt;
  logic [40:0]                 dx_r, dx_nxt, dy_r, dy_nxt;
  logic [47:0]                 sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [MW-1:0]        mx_r, mx_nxt, my_r, my_nxt;
  logic [SCW-1:0]              cnt_r, cnt_nxt;
  logic                        side_r, side_nxt;
  logic [2:0]                  hit_r, hit_nxt;
  logic [32:0]                 d_r, d_nxt;
  logic [HW-1:0]               h_r, h_nxt;
  logic                        stripe_r, stripe_nxt;
  logic [63:0]                 out_data_r, out_data_nxt;

  grc_pkg::arith_req_t areq;
  grc_pkg::arith_rsp_t arsp;

  grc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  // Tile map memory.
  logic [2:0]    tiles_mem [DEPTH];
  logic [2:0]    tile_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [2:0]    mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tiles_mem[mem_wa] <= mem_wd;
    end
    tile_q_r <= tiles_mem[mem_ra];
  end

  function automatic logic [RW-2:0] ray_mag(input logic signed [RW-1:0] r);
    return r[RW-1] ? (RW-1)'(-r) : (RW-1)'(r);
  endfunction

  function automatic logic [15:0] vec_mag(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  logic                     in_acc;
  logic signed [11:0]       num_s;
  logic [35:0]              pm;
  logic signed [36:0]       pprod;
  logic signed [RW-1:0]     pshift;
  logic [12:0]              frac_f;
  logic                     lt;
  logic signed [MW-1:0]     mx_step, my_step;
  logic                     oob;
  logic [2:0]               hit_now;
  logic [47:0]              dsel, ddel, draw;
  logic [54:0]              wm;
  logic signed [55:0]       wp;
  logic signed [41:0]       wfl;
  logic signed [43:0]       wv, wneg;
  logic [15:0]              wpos;
  logic signed [RW-1:0]     rsel;
  logic [HW-1:0]            hh, top_v, bot_v;
  logic [15:0]              color;
  logic [15:0]              dist_out;

  assign in_tready  = (state_r == grc_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    column_nxt    = column_r;
    num_mag_nxt   = num_mag_r;
    cam_neg_nxt   = cam_neg_r;
    cam_mag_nxt   = cam_mag_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    cnt_nxt       = cnt_r;
    side_nxt      = side_r;
    hit_nxt       = hit_r;
    d_nxt         = d_r;
    h_nxt         = h_r;
    stripe_nxt    = stripe_r;
    out_data_nxt  = out_data_r;

    areq.start = 1'b0;
    areq.op    = grc_pkg::AR_MUL;
    areq.a     = '0;
    areq.b     = '0;

    mem_we = 1'b0;
    mem_wa = clr_addr_r;
    mem_wd = grc_pkg::TILE_EMPTY;

    num_s = $signed({3'b0, in_column, 1'b0}) - $signed(12'(SCREEN_WIDTH));

    // Shared post-processing of the ray multiplications.
    pm     = arsp.result[35:0];
    pprod  = $signed({1'b0, pm});
    pshift = '0;

    frac_f = '0;

    // One DDA step: a tie steps in y.
    lt      = sx_r < sy_r;
    mx_step = rx_r[RW-1] ? mx_r - MW'(1) : mx_r + MW'(1);
    my_step = ry_r[RW-1] ? my_r - MW'(1) : my_r + MW'(1);
    mem_ra  = AW'(AW'(my_r) * AW'(MAP_WIDTH) + AW'(mx_r));

    oob = mx_r[MW-1] || (mx_r >= $signed(MW'(MAP_WIDTH))) ||
          my_r[MW-1] || (my_r >= $signed(MW'(MAP_HEIGHT)));
    hit_now = oob ? grc_pkg::TILE_WALL : tile_q_r;

    dsel = side_r ? sy_r : sx_r;
    ddel = side_r ? 48'(dy_r) : 48'(dx_r);
    draw = (dsel >= ddel) ? dsel - ddel : '0;

    rsel = side_r ? rx_r : ry_r;
    wpos = side_r ? player_x_r : player_y_r;
    wm   = arsp.result[54:0];
    wp   = rsel[RW-1] ? -$signed({1'b0, wm}) : $signed({1'b0, wm});
    wfl  = 42'(wp >>> 14);
    wv   = $signed({24'b0, wpos, 4'b0}) + 44'(wfl);
    wneg = -wv;

    hh    = h_r >> 1;
    top_v = (hh > HW'(VIEW_HEIGHT / 2)) ? '0 : HW'(VIEW_HEIGHT / 2) - hh;
    bot_v = (HW'(VIEW_HEIGHT / 2) + hh > HW'(VIEW_HEIGHT - 1)) ?
            HW'(VIEW_HEIGHT - 1) : HW'(VIEW_HEIGHT / 2) + hh;

    color = grc_pkg::tile_color(hit_r);
    if (side_r) begin
      color = grc_pkg::halve(color);
    end
    if (stripe_r) begin
      color = grc_pkg::halve(color);
    end
    dist_out = (d_r[32:22] != '0) ? 16'hFFFF : d_r[21:6];

    unique case (state_r)
      grc_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = grc_pkg::ST_IDLE;
        end
      end

      grc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == grc_pkg::OP_TILE) begin
            mem_wa = AW'(AW'(in_tile_row) * AW'(MAP_WIDTH) + AW'(in_tile_col));
            mem_wd = in_tile_code;
            mem_we = (in_tile_code <= grc_pkg::TILE_EXIT) &&
                     ({28'b0, in_tile_row} < 32'(MAP_HEIGHT)) &&
                     ({28'b0, in_tile_col} < 32'(MAP_WIDTH));
          end else begin
            column_nxt  = in_column;
            cam_neg_nxt = num_s[11];
            num_mag_nxt = num_s[11] ? 11'(-num_s) : 11'(num_s);
            issued_nxt  = 1'b0;
            state_nxt   = grc_pkg::ST_CAM;
          end
        end
      end

      grc_pkg::ST_CAM: begin
        areq.op = grc_pkg::AR_DIV;
        areq.a  = 64'({num_mag_r, 14'b0});
        areq.b  = 33'(SCREEN_WIDTH);
        areq.start = !issued_r;
        issued_nxt = 1'b1;
        if (arsp.done) begin
          cam_mag_nxt = arsp.result[grc_pkg::CAM_W-1:0];
          issued_nxt  = 1'b0;
          state_nxt   = grc_pkg::ST_RAYX;
        end
      end

      grc_pkg::ST_RAYX, grc_pkg::ST_RAYY: begin
        areq.op = grc_pkg::AR_MUL;
        areq.a  = 64'(cam_mag_r);
        areq.b  = 33'((state_r == grc_pkg::ST_RAYX) ? vec_mag(plane_x_r)
                                                    : vec_mag(plane_y_r));
        areq.start = !issued_r;
        issued_nxt = 1'b1;
        if (arsp.done) begin
          issued_nxt = 1'b0;
          if (state_r == grc_pkg::ST_RAYX) begin
            if (plane_x_r[15] ^ cam_neg_r) pprod = -$signed({1'b0, pm});
            pshift    = RW'(pprod >>> 14);
            rx_nxt    = RW'(dir_x_r) + pshift;
            state_nxt = grc_pkg::ST_RAYY;
          end else begin
            if (plane_y_r[15] ^ cam_neg_r) pprod = -$signed({1'b0, pm});
            pshift    = RW'(pprod >>> 14);
            ry_nxt    = RW'(dir_y_r) + pshift;
            state_nxt = grc_pkg::ST_DELX;
          end
        end
      end

      grc_pkg::ST_DELX, grc_pkg::ST_DELY: begin
        areq.op = grc_pkg::AR_DIV;
        areq.a  = 64'h4000_0000;
        areq.b  = 33'((state_r == grc_pkg::ST_DELX) ? ray_mag(rx_r) : ray_mag(ry_r));
        areq.start = !issued_r;
        issued_nxt = 1'b1;
        if (arsp.done) begin
          issued_nxt = 1'b0;
          // A zero ray component never reaches that side.
          if (state_r == grc_pkg::ST_DELX) begin
            dx_nxt    = (rx_r == '0) ? grc_pkg::INF_DIST : 41'(arsp.result[30:0]);
            state_nxt = grc_pkg::ST_DELY;
          end else begin
            dy_nxt    = (ry_r == '0) ? grc_pkg::INF_DIST : 41'(arsp.result[30:0]);
            state_nxt = grc_pkg::ST_SIDEX;
          end
        end
      end

      grc_pkg::ST_SIDEX, grc_pkg::ST_SIDEY: begin
        if (state_r == grc_pkg::ST_SIDEX) begin
          frac_f = rx_r[RW-1] ? {1'b0, player_x_r[11:0]}
                              : 13'd4096 - {1'b0, player_x_r[11:0]};
          areq.a = 64'(dx_r);
        end else begin
          frac_f = ry_r[RW-1] ? {1'b0, player_y_r[11:0]}
                              : 13'd4096 - {1'b0, player_y_r[11:0]};
          areq.a = 64'(dy_r);
        end
        areq.op = grc_pkg::AR_MUL;
        areq.b  = 33'(frac_f);
        areq.start = !issued_r;
        issued_nxt = 1'b1;
        if (arsp.done) begin
          issued_nxt = 1'b0;
          if (state_r == grc_pkg::ST_SIDEX) begin
            sx_nxt    = arsp.result[59:12];
            state_nxt = grc_pkg::ST_SIDEY;
          end else begin
            sy_nxt    = arsp.result[59:12];
            mx_nxt    = $signed(MW'(player_x_r[15:12]));
            my_nxt    = $signed(MW'(player_y_r[15:12]));
            cnt_nxt   = '0;
            side_nxt  = 1'b0;
            state_nxt = grc_pkg::ST_STEP;
          end
        end
      end

      grc_pkg::ST_STEP: begin
        if (lt) begin
          sx_nxt   = sx_r + 48'(dx_r);
          mx_nxt   = mx_step;
          side_nxt = 1'b0;
        end else begin
          sy_nxt   = sy_r + 48'(dy_r);
          my_nxt   = my_step;
          side_nxt = 1'b1;
        end
        cnt_nxt   = cnt_r + SCW'(1);
        state_nxt = grc_pkg::ST_CHECK;
      end

      grc_pkg::ST_CHECK: begin
        // The map read issued from the updated cell lands here.
        hit_nxt = hit_now;
        if ((hit_now != grc_pkg::TILE_EMPTY) || (cnt_r == SCW'(MAX_STEPS))) begin
          state_nxt = grc_pkg::ST_DIST;
        end else begin
          state_nxt = grc_pkg::ST_STEP;
        end
      end

      grc_pkg::ST_DIST: begin
        if (draw < 48'(grc_pkg::MIN_DIST)) begin
          d_nxt = grc_pkg::MIN_DIST;
        end else if (draw > 48'(grc_pkg::DIST_CAP)) begin
          d_nxt = grc_pkg::DIST_CAP;
        end else begin
          d_nxt = draw[32:0];
        end
        issued_nxt = 1'b0;
        state_nxt  = grc_pkg::ST_HGT;
      end

      grc_pkg::ST_HGT: begin
        areq.op = grc_pkg::AR_DIV;
        areq.a  = 64'(VIEW_HEIGHT) << 16;
        areq.b  = d_r;
        areq.start = !issued_r;
        issued_nxt = 1'b1;
        if (arsp.done) begin
          h_nxt      = arsp.result[HW-1:0];
          issued_nxt = 1'b0;
          state_nxt  = grc_pkg::ST_WHIT;
        end
      end

      grc_pkg::ST_WHIT: begin
        areq.op = grc_pkg::AR_MUL;
        areq.a  = 64'(ray_mag(rsel));
        areq.b  = d_r;
        areq.start = !issued_r;
        issued_nxt = 1'b1;
        if (arsp.done) begin
          // Truncating division by 8192 is odd when bit 13 of the magnitude is set.
          stripe_nxt = wv[43] ? wneg[13] : wv[13];
          issued_nxt = 1'b0;
          state_nxt  = grc_pkg::ST_EMIT;
        end
      end

      grc_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {6'b0, color, side_r, hit_r, bot_v[6:0], top_v[6:0],
                           dist_out, column_r};
          out_valid_nxt = 1'b1;
          state_nxt     = grc_pkg::ST_IDLE;
        end
      end

      default: state_nxt = grc_pkg::ST_IDLE;
    endcase

    if (state_r == grc_pkg::ST_STEP) begin
      mem_ra = AW'(AW'(my_nxt) * AW'(MAP_WIDTH) + AW'(mx_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grc_pkg::ST_CLEAR;
      issued_r    <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    column_r   <= column_nxt;
    num_mag_r  <= num_mag_nxt;
    cam_neg_r  <= cam_neg_nxt;
    cam_mag_r  <= cam_mag_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    cnt_r      <= cnt_nxt;
    side_r     <= side_nxt;
    hit_r      <= hit_nxt;
    d_r        <= d_nxt;
    h_r        <= h_nxt;
    stripe_r   <= stripe_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sv/grc_arith.sv =====
// ----------------------------------------------------------------------------
// grc_arith
// Shared bit-serial multiplier and restoring divider around one 64-bit adder.
// ----------------------------------------------------------------------------
module grc_arith (
  input  logic                 clk,
  input  logic                 rst_n,
  input  grc_pkg::arith_req_t  req,
  output grc_pkg::arith_rsp_t  rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  grc_pkg::arith_op_t            op_r, op_nxt;
  logic [grc_pkg::AR_W-1:0]      acc_r, acc_nxt;
  logic [grc_pkg::AR_W-1:0]      opa_r, opa_nxt;
  logic [grc_pkg::AR_BW-1:0]     opb_r, opb_nxt;
  logic [4:0]                    cnt_r, cnt_nxt;

  logic [grc_pkg::AR_W-1:0]      rem_shift;
  logic [grc_pkg::AR_W-1:0]      add_x, add_y;
  logic                          add_cin;
  logic [grc_pkg::AR_W:0]        sum;

  always_comb begin
    rem_shift = {acc_r[grc_pkg::AR_W-2:0], opa_r[31]};
    if (op_r == grc_pkg::AR_DIV) begin
      // Trial subtract: the carry out is set when the divisor fits.
      add_x   = rem_shift;
      add_y   = ~{{(grc_pkg::AR_W - grc_pkg::AR_BW){1'b0}}, opb_r};
      add_cin = 1'b1;
    end else begin
      add_x   = acc_r;
      add_y   = opa_r;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_x} + {1'b0, add_y} + {{grc_pkg::AR_W{1'b0}}, add_cin};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    cnt_nxt  = cnt_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      acc_nxt  = '0;
      opa_nxt  = req.a;
      opb_nxt  = req.b;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (op_r == grc_pkg::AR_MUL) begin
        if (opb_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          if (opb_r[0]) begin
            acc_nxt = sum[grc_pkg::AR_W-1:0];
          end
          opa_nxt = {opa_r[grc_pkg::AR_W-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[grc_pkg::AR_BW-1:1]};
        end
      end else begin
        acc_nxt = sum[grc_pkg::AR_W] ? sum[grc_pkg::AR_W-1:0] : rem_shift;
        opa_nxt = {opa_r[grc_pkg::AR_W-2:0], sum[grc_pkg::AR_W]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == grc_pkg::AR_DIV) ? {32'b0, opa_r[31:0]} : acc_r;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks grid_raycast_column: tile writes and column casts are driven on the
// input stream, every cast beat is traced by a DDA predictor kept inside the
// bench, and each result beat is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SCR_W       = 160;
  localparam int  VIEW_H      = 108;
  localparam int  GRID_W      = 16;
  localparam int  GRID_H      = 16;
  localparam int  STEP_LIMIT  = 40;
  localparam int  STALL_LIMIT = 20000;
  localparam int  RAND_PHASES = 8;
  localparam int  PHASE_ITEMS = 200;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef struct {
    logic [7:0]  column;
    logic [15:0] distance;
    logic [6:0]  top;
    logic [6:0]  bottom;
    logic [2:0]  tile;
    logic        side;
    logic [15:0] color;
    bit          typed;
    logic [2:0]  typed_tile;
    logic        typed_side;
  } column_result_t;

  typedef struct {
    logic       op;
    logic [7:0] column;
    logic [3:0] row;
    logic [3:0] tcol;
    logic [2:0] code;
    bit         typed;
    logic [2:0] tile;
    logic       side;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] pos_x, pos_y, view_dx, view_dy, cam_px, cam_py;
  logic [2:0]  tile_map [GRID_W*GRID_H];
  column_result_t pending_columns[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_gap_pct = 0;
  int  stall_pct = 0;
  bit  next_typed = 1'b0;
  logic [2:0] next_tile;
  logic next_side;

  localparam logic [15:0] BASE_COLOR [8] = '{16'h9144, 16'h9144, 16'h2394, 16'h2C88,
                                               16'h8264, 16'h16EB, 16'h9144, 16'h9144};

  grid_raycast_column dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] dim(logic [15:0] c);
    logic [4:0] r, b;
    logic [5:0] g;
    r = c[15:11] >> 1;
    g = c[10:5] >> 1;
    b = c[4:0] >> 1;
    return {r, g, b};
  endfunction

  function automatic void axis_start(longint r, logic [15:0] pos, output longint delta,
                                     output longint first, output int dir);
    longint frac, mag;
    frac  = longint'(pos[11:0]);
    mag   = (r < 0) ? -r : r;
    delta = (mag == 0) ? (longint'(1) << 40) : (longint'(1) << 30) / mag;
    dir   = (r < 0) ? -1 : 1;
    first = (r < 0) ? (frac * delta) >> 12 : ((4096 - frac) * delta) >> 12;
  endfunction

  function automatic column_result_t trace_column(logic [7:0] column);
    column_result_t res;
    longint cam, rx, ry, dx, dy, sx, sy, d, h, top, bottom, w;
    int stx, sty, mx, my;
    logic [2:0] hit;
    logic side;
    cam = (2 * longint'(column) - SCR_W) * 16384 / SCR_W;
    rx = longint'($signed(view_dx)) + ((longint'($signed(cam_px)) * cam) >>> 14);
    ry = longint'($signed(view_dy)) + ((longint'($signed(cam_py)) * cam) >>> 14);
    axis_start(rx, pos_x, dx, sx, stx);
    axis_start(ry, pos_y, dy, sy, sty);
    mx = pos_x[15:12];
    my = pos_y[15:12];
    side = 1'b0;
    hit = 3'd1;
    for (int n = 0; n < STEP_LIMIT; n++) begin
      if (sx < sy) begin
        sx += dx; mx += stx; side = 1'b0;
      end else begin
        sy += dy; my += sty; side = 1'b1;
      end
      // Cells outside the map act as plain walls.
      if (mx < 0 || mx >= GRID_W || my < 0 || my >= GRID_H) hit = 3'd1;
      else hit = tile_map[my*GRID_W + mx];
      if (hit != 3'd0) break;
    end
    d = side ? ((sy >= dy) ? sy - dy : 0) : ((sx >= dx) ? sx - dx : 0);
    if (d < 5243) d = 5243;
    if (d > (longint'(1) << 32)) d = longint'(1) << 32;
    h = (longint'(VIEW_H) << 16) / d;
    top = VIEW_H / 2 - h / 2;
    bottom = VIEW_H / 2 + h / 2;
    if (top < 0) top = 0;
    if (bottom > VIEW_H - 1) bottom = VIEW_H - 1;
    res.color = BASE_COLOR[hit];
    if (side) res.color = dim(res.color);
    w = side ? (longint'(pos_x) << 4) + ((d * rx) >>> 14)
             : (longint'(pos_y) << 4) + ((d * ry) >>> 14);
    if ((w / 8192) % 2 != 0) res.color = dim(res.color);
    res.column = column;
    res.distance = ((d >> 6) > 65535) ? 16'hFFFF : 16'(d >> 6);
    res.top = 7'(top);
    res.bottom = 7'(bottom);
    res.tile = hit;
    res.side = side;
    res.typed = 1'b0;
    return res;
  endfunction

  // Input beats update the bench map or queue a predicted column.
  always @(posedge clk) begin
    column_result_t exp_col;
    logic [63:0] got;
    longint exp_f[7], act_f[7];
    string names[7];
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == grc_pkg::OP_TILE) begin
        if (in_tdata[18:16] <= grc_pkg::TILE_EXIT)
          tile_map[in_tdata[11:8]*GRID_W + in_tdata[15:12]] = in_tdata[18:16];
      end else begin
        exp_col = trace_column(in_tdata[7:0]);
        exp_col.typed = next_typed;
        exp_col.typed_tile = next_tile;
        exp_col.typed_side = next_side;
        pending_columns.push_back(exp_col);
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_columns.size() == 0) begin
        $error("result beat with no cast outstanding: %h", got);
        errors++;
      end else begin
        exp_col = pending_columns.pop_front();
        names = '{"out_column", "wall_distance", "wall_top", "wall_bottom",
                  "hit_tile", "hit_side", "wall_color"};
        exp_f = '{exp_col.column, exp_col.distance, exp_col.top, exp_col.bottom,
                  exp_col.tile, exp_col.side, exp_col.color};
        act_f = '{got[7:0], got[23:8], got[30:24], got[37:31], got[40:38], got[41],
                  got[57:42]};
        // Hand-written outcomes of the directed rows override the predictor.
        if (exp_col.typed) begin
          exp_f[4] = exp_col.typed_tile;
          exp_f[5] = exp_col.typed_side;
        end
        for (int i = 0; i < 7; i++)
          if (exp_f[i] != act_f[i]) begin
            $error("%s expected %0d got %0d", names[i], exp_f[i], act_f[i]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send(logic op, logic [7:0] column, logic [3:0] row, logic [3:0] tcol,
                      logic [2:0] code);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'd0, code, tcol, row, column};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    // A trailing tile write may still be in flight.
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      grc_pkg::CFG_PLAYER_X: pos_x = value;
      grc_pkg::CFG_PLAYER_Y: pos_y = value;
      grc_pkg::CFG_DIR_X:    view_dx = value;
      grc_pkg::CFG_DIR_Y:    view_dy = value;
      grc_pkg::CFG_PLANE_X:  cam_px = value;
      grc_pkg::CFG_PLANE_Y:  cam_py = value;
      default: ;
    endcase
  endtask

  task automatic setup_view(int phase);
    logic [15:0] px, py, ddx, ddy, pdx, pdy;
    px = 16'($urandom_range(16'h0800, 16'hF7FF));
    py = 16'($urandom_range(16'h0800, 16'hF7FF));
    ddx = 16'($urandom_range(0, 32767) - 16384);
    ddy = 16'($urandom_range(0, 32767) - 16384);
    pdx = 16'($urandom_range(0, 24000) - 12000);
    pdy = 16'($urandom_range(0, 24000) - 12000);
    case (phase)
      1: begin px = 16'd0; py = 16'hFFFF; ddx = 16'h8000; pdy = 16'h7FFF; end
      3: begin px = 16'hFFFF; py = 16'd0; ddy = 16'h7FFF; pdx = 16'h8000; end
      5: begin ddx = 16'd0; pdx = 16'd0; end
      6: begin ddy = 16'd0; pdy = 16'd0; end
      default: ;
    endcase
    write_reg(grc_pkg::CFG_PLAYER_X, px);
    write_reg(grc_pkg::CFG_PLAYER_Y, py);
    write_reg(grc_pkg::CFG_DIR_X, ddx);
    write_reg(grc_pkg::CFG_DIR_Y, ddy);
    write_reg(grc_pkg::CFG_PLANE_X, pdx);
    write_reg(grc_pkg::CFG_PLANE_Y, pdy);
    if (phase == 2) write_reg(CFG_SPARE, 16'hFFFF);
  endtask

  stim_row_t directed [] = '{
    '{grc_pkg::OP_CAST, 8'd80,  4'd0,  4'd0,  3'd0, 1'b1, 3'd1, 1'b1},
    '{grc_pkg::OP_CAST, 8'd0,   4'd15, 4'd15, 3'd7, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd159, 4'd0,  4'd0,  3'd0, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd255, 4'd0,  4'd0,  3'd0, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_TILE, 8'd255, 4'd2,  4'd2,  3'd7, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_TILE, 8'd0,   4'd2,  4'd2,  3'd6, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd80,  4'd0,  4'd0,  3'd0, 1'b1, 3'd1, 1'b1},
    '{grc_pkg::OP_TILE, 8'd0,   4'd2,  4'd2,  3'd5, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd80,  4'd0,  4'd0,  3'd0, 1'b1, 3'd5, 1'b1},
    '{grc_pkg::OP_TILE, 8'd0,   4'd3,  4'd2,  3'd2, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_TILE, 8'd0,   4'd2,  4'd2,  3'd0, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd80,  4'd0,  4'd0,  3'd0, 1'b1, 3'd2, 1'b1},
    '{grc_pkg::OP_TILE, 8'd0,   4'd3,  4'd1,  3'd1, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_TILE, 8'd0,   4'd3,  4'd3,  3'd3, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_TILE, 8'd0,   4'd3,  4'd4,  3'd4, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_TILE, 8'd0,   4'd0,  4'd0,  3'd1, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd20,  4'd0,  4'd0,  3'd0, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd60,  4'd0,  4'd0,  3'd0, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd110, 4'd0,  4'd0,  3'd0, 1'b0, 3'd0, 1'b0},
    '{grc_pkg::OP_CAST, 8'd140, 4'd0,  4'd0,  3'd0, 1'b0, 3'd0, 1'b0}
  };

  initial begin
    int items;
    pos_x = grc_pkg::PLAYER_X_RST; pos_y = grc_pkg::PLAYER_Y_RST;
    view_dx = grc_pkg::DIR_X_RST; view_dy = grc_pkg::DIR_Y_RST;
    cam_px = grc_pkg::PLANE_X_RST; cam_py = grc_pkg::PLANE_Y_RST;
    foreach (tile_map[i]) tile_map[i] = grc_pkg::TILE_EMPTY;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      next_typed = directed[i].typed;
      next_tile = directed[i].tile;
      next_side = directed[i].side;
      send(directed[i].op, directed[i].column, directed[i].row, directed[i].tcol,
           directed[i].code);
    end
    drain();
    next_typed = 1'b0;

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      send_gap_pct = (phase % 4 == 1) ? 57 : (phase % 4 == 3) ? 11 : 0;
      stall_pct    = (phase % 4 == 2) ? 57 : (phase % 4 == 3) ? 11 : 0;
      setup_view(phase);
      items = 0;
      // Lay out a fresh scatter of walls, then cast through it with some edits.
      repeat (40) begin
        send(grc_pkg::OP_TILE, 8'($urandom), 4'($urandom), 4'($urandom),
             ($urandom_range(99) < 35) ? 3'($urandom_range(1, 5)) : grc_pkg::TILE_EMPTY);
        items++;
      end
      while (items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 75)
          send(grc_pkg::OP_CAST, ($urandom_range(99) < 90) ? 8'($urandom_range(0, SCR_W - 1))
                                                           : 8'($urandom),
               4'($urandom), 4'($urandom), 3'($urandom));
        else
          send(grc_pkg::OP_TILE, 8'($urandom), 4'($urandom), 4'($urandom), 3'($urandom));
        items++;
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (errors == 0 && pending_columns.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/grc_pkg.sv
sv/grc_arith.sv
sv/grid_raycast_column.sv
tb/testbench.sv
